// File: rtl/sfc_pkg.sv
// Package for the segment free list with coalescing.
// Holds default sizes, status and function codes, the controller state type
// and the command and status structs shared by the controller and datapath.
package sfc_pkg;

    // Default sizes.
    localparam int ALLOC_SLOTS_DEF = 64;
    localparam int FREE_SLOTS_DEF  = 64;
    localparam int ADDR_BITS_DEF   = 32;

    // Request function codes.
    localparam logic [1:0] FN_RECORD = 2'd0;
    localparam logic [1:0] FN_FREE   = 2'd1;
    localparam logic [1:0] FN_SEED   = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_AL_SCAN,
        S_FR_RD,
        S_FR_CHK,
        S_FS_RD,
        S_FS_CHK,
        S_DEC_LO,
        S_DEC_UP,
        S_ACT,
        S_SH_RD,
        S_SH_WR,
        S_FREED,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       a_inc;
        logic       a_write;
        logic       a_clear;
        logic       cap_found;
        logic       cap_lo;
        logic       cap_up;
        logic       dec_lo;
        logic       dec_up;
        logic       wr_merge;
        logic       sh_down;
        logic       sh_up;
        logic       sh_rd;
        logic       sh_wr;
        logic       sh_fin;
        logic       set_st;
        logic [1:0] st_val;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       null_addr;
        logic       slot_valid;
        logic       a_last;
        logic       start_match;
        logic       f_at_end;
        logic       f_less;
        logic       mlo;
        logic       mup;
        logic       full;
        logic       sh_end;
    } t_sts;

endpackage

// File: rtl/sfc_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module sfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sfc_ctrl.sv
// Controller state machine of the segment free list.
// Depends on sfc_pkg; drives sfc_dp through the command struct.
module sfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sfc_pkg::t_sts i_sts,
    output sfc_pkg::t_cmd o_cmd
);

    sfc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    sfc_pkg::t_cmd   cmd;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Result valid holds until taken, and is set when a result is loaded.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sfc_pkg::S_DISPATCH;
            end
            sfc_pkg::S_DISPATCH: begin
                if (i_sts.func == sfc_pkg::FN_NONE || i_sts.null_addr) begin
                    n_state = sfc_pkg::S_DONE;
                end else if (i_sts.func == sfc_pkg::FN_RECORD) begin
                    n_state = sfc_pkg::S_AL_SCAN;
                end else if (i_sts.func == sfc_pkg::FN_FREE) begin
                    n_state = sfc_pkg::S_FR_RD;
                end else begin
                    n_state = sfc_pkg::S_FS_RD;
                end
            end
            sfc_pkg::S_AL_SCAN: begin
                if (!i_sts.slot_valid || i_sts.a_last) n_state = sfc_pkg::S_DONE;
            end
            sfc_pkg::S_FR_RD: n_state = sfc_pkg::S_FR_CHK;
            sfc_pkg::S_FR_CHK: begin
                if (i_sts.slot_valid && i_sts.start_match) begin
                    n_state = sfc_pkg::S_FS_RD;
                end else if (i_sts.a_last) begin
                    n_state = sfc_pkg::S_DONE;
                end else begin
                    n_state = sfc_pkg::S_FR_RD;
                end
            end
            sfc_pkg::S_FS_RD: begin
                n_state = i_sts.f_at_end ? sfc_pkg::S_DEC_LO : sfc_pkg::S_FS_CHK;
            end
            sfc_pkg::S_FS_CHK: begin
                n_state = i_sts.f_less ? sfc_pkg::S_FS_RD : sfc_pkg::S_DEC_LO;
            end
            sfc_pkg::S_DEC_LO: n_state = sfc_pkg::S_DEC_UP;
            sfc_pkg::S_DEC_UP: n_state = sfc_pkg::S_ACT;
            sfc_pkg::S_ACT: begin
                if (i_sts.mlo && i_sts.mup) begin
                    n_state = sfc_pkg::S_SH_RD;
                end else if (i_sts.mlo || i_sts.mup) begin
                    n_state = sfc_pkg::S_FREED;
                end else if (i_sts.full) begin
                    n_state = sfc_pkg::S_DONE;
                end else begin
                    n_state = sfc_pkg::S_SH_RD;
                end
            end
            sfc_pkg::S_SH_RD: begin
                n_state = i_sts.sh_end ? sfc_pkg::S_FREED : sfc_pkg::S_SH_WR;
            end
            sfc_pkg::S_SH_WR: n_state = sfc_pkg::S_SH_RD;
            sfc_pkg::S_FREED: n_state = sfc_pkg::S_DONE;
            sfc_pkg::S_DONE: begin
                if (out_free) n_state = sfc_pkg::S_IDLE;
            end
            default: n_state = sfc_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd = '0;
        case (r_state)
            sfc_pkg::S_IDLE: begin
                cmd.load = i_in_valid;
            end
            sfc_pkg::S_DISPATCH: begin
                if (i_sts.func != sfc_pkg::FN_NONE && i_sts.null_addr) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = sfc_pkg::STS_NULL;
                end
            end
            sfc_pkg::S_AL_SCAN: begin
                if (!i_sts.slot_valid) begin
                    cmd.a_write = 1'b1;
                end else if (i_sts.a_last) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = sfc_pkg::STS_FULL;
                end else begin
                    cmd.a_inc = 1'b1;
                end
            end
            sfc_pkg::S_FR_CHK: begin
                if (i_sts.slot_valid && i_sts.start_match) begin
                    cmd.cap_found = 1'b1;
                end else if (i_sts.a_last) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = sfc_pkg::STS_NOT_FOUND;
                end else begin
                    cmd.a_inc = 1'b1;
                end
            end
            sfc_pkg::S_FS_CHK: begin
                cmd.cap_lo = i_sts.f_less;
                cmd.cap_up = !i_sts.f_less;
            end
            sfc_pkg::S_DEC_LO: cmd.dec_lo = 1'b1;
            sfc_pkg::S_DEC_UP: cmd.dec_up = 1'b1;
            sfc_pkg::S_ACT: begin
                if (i_sts.mlo || i_sts.mup) begin
                    cmd.wr_merge = 1'b1;
                    cmd.sh_down  = i_sts.mlo && i_sts.mup;
                end else if (i_sts.full) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = sfc_pkg::STS_FULL;
                end else begin
                    cmd.sh_up = 1'b1;
                end
            end
            sfc_pkg::S_SH_RD: begin
                cmd.sh_rd  = !i_sts.sh_end;
                cmd.sh_fin = i_sts.sh_end;
            end
            sfc_pkg::S_SH_WR: cmd.sh_wr = 1'b1;
            sfc_pkg::S_FREED: begin
                cmd.a_clear = (i_sts.func == sfc_pkg::FN_FREE);
            end
            sfc_pkg::S_DONE: cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == sfc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/sfc_dp.sv
// Datapath of the segment free list: allocated and free tables in RAM,
// scan counters, neighbor registers, merge decisions and result registers.
// Depends on sfc_pkg and sfc_ram; controlled by sfc_ctrl.
module sfc_dp #(
    parameter int ALLOC_SLOTS = sfc_pkg::ALLOC_SLOTS_DEF,
    parameter int FREE_SLOTS  = sfc_pkg::FREE_SLOTS_DEF,
    parameter int ADDR_BITS   = sfc_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_func,
    input  logic [31:0]                     i_seg_start,
    input  logic [31:0]                     i_seg_size,
    input  logic [15:0]                     i_owner_id,
    input  sfc_pkg::t_cmd                   i_cmd,
    output sfc_pkg::t_sts                   o_sts,
    output logic [$clog2(FREE_SLOTS+1)-1:0] o_free_cnt,
    output logic [1:0]                      o_status,
    output logic [15:0]                     o_freed_owner,
    output logic [6:0]                      o_free_entries
);

    localparam int AAW = $clog2(ALLOC_SLOTS);
    localparam int FAW = $clog2(FREE_SLOTS);
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int CW  = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    // Control state.
    logic [ALLOC_SLOTS-1:0] r_valid;
    logic [FCW-1:0]         r_count;

    // Request and working registers.
    logic [1:0]           r_func;
    logic [ADDR_BITS-1:0] r_s;
    logic [31:0]          r_size;
    logic [15:0]          r_owner;
    logic [AAW-1:0]       r_aidx;
    logic [FCW-1:0]       r_fidx;
    logic [FCW-1:0]       r_p;
    logic                 r_lo_vld, r_up_vld;
    logic [ADDR_BITS-1:0] r_lo_start, r_up_start;
    logic [31:0]          r_lo_size, r_up_size;
    logic                 r_mlo, r_mup, r_dir_down;
    logic [31:0]          r_base, r_sum;
    logic [1:0]           r_status;
    logic [15:0]          r_freed;
    logic [1:0]           r_o_status;
    logic [15:0]          r_o_freed;
    logic [6:0]           r_o_entries;

    // RAM read data.
    logic [ADDR_BITS-1:0] rd_astart, rd_fstart;
    logic [31:0]          rd_asize, rd_fsize;
    logic [15:0]          rd_aowner;

    // Free table port signals.
    logic [FCW-1:0]       f_raddr, f_waddr;
    logic                 f_we_start, f_we_size;
    logic [ADDR_BITS-1:0] f_wstart;
    logic [31:0]          f_wsize;

    // Merge arithmetic.
    logic [CW-1:0] lo_diff, up_diff;
    logic [32:0]   lo_add, up_add;
    logic          mlo_c, mup_c;

    // Allocated segment tables, addressed by the scan index.
    sfc_ram #(.WIDTH(ADDR_BITS), .DEPTH(ALLOC_SLOTS)) u_astart (
        .i_clk(i_clk), .i_we(i_cmd.a_write), .i_waddr(r_aidx), .i_wdata(r_s),
        .i_raddr(r_aidx), .o_rdata(rd_astart)
    );
    sfc_ram #(.WIDTH(32), .DEPTH(ALLOC_SLOTS)) u_asize (
        .i_clk(i_clk), .i_we(i_cmd.a_write), .i_waddr(r_aidx), .i_wdata(r_size),
        .i_raddr(r_aidx), .o_rdata(rd_asize)
    );
    sfc_ram #(.WIDTH(16), .DEPTH(ALLOC_SLOTS)) u_aowner (
        .i_clk(i_clk), .i_we(i_cmd.a_write), .i_waddr(r_aidx), .i_wdata(r_owner),
        .i_raddr(r_aidx), .o_rdata(rd_aowner)
    );

    // Free segment tables.
    sfc_ram #(.WIDTH(ADDR_BITS), .DEPTH(FREE_SLOTS)) u_fstart (
        .i_clk(i_clk), .i_we(f_we_start), .i_waddr(f_waddr[FAW-1:0]),
        .i_wdata(f_wstart), .i_raddr(f_raddr[FAW-1:0]), .o_rdata(rd_fstart)
    );
    sfc_ram #(.WIDTH(32), .DEPTH(FREE_SLOTS)) u_fsize (
        .i_clk(i_clk), .i_we(f_we_size), .i_waddr(f_waddr[FAW-1:0]),
        .i_wdata(f_wsize), .i_raddr(f_raddr[FAW-1:0]), .o_rdata(rd_fsize)
    );

    // Free table read address: scan index, or its neighbor while shifting.
    always_comb begin
        f_raddr = r_fidx;
        if (i_cmd.sh_rd) begin
            f_raddr = r_dir_down ? r_fidx + FCW'(1) : r_fidx - FCW'(1);
        end
    end

    // Free table writes: merge update, shift step or new entry.
    always_comb begin
        f_we_start = 1'b0;
        f_we_size  = 1'b0;
        f_waddr    = r_p;
        f_wstart   = r_s;
        f_wsize    = r_sum;
        if (i_cmd.wr_merge) begin
            f_we_size = 1'b1;
            if (r_mlo) begin
                f_waddr = r_p - FCW'(1);
                f_wsize = r_mup ? r_sum : r_base;
            end else begin
                f_we_start = 1'b1;
            end
        end else if (i_cmd.sh_wr) begin
            f_we_start = 1'b1;
            f_we_size  = 1'b1;
            f_waddr    = r_fidx;
            f_wstart   = rd_fstart;
            f_wsize    = rd_fsize;
        end else if (i_cmd.sh_fin && !r_dir_down) begin
            f_we_start = 1'b1;
            f_we_size  = 1'b1;
            f_wsize    = r_size;
        end
    end

    // Contiguity and size overflow checks for both neighbors.
    assign lo_diff = CW'(r_s) - CW'(r_lo_start);
    assign lo_add  = {1'b0, r_lo_size} + {1'b0, r_size};
    assign mlo_c   = r_lo_vld && (lo_diff == CW'(r_lo_size)) && !lo_add[32];
    assign up_diff = CW'(r_up_start) - CW'(r_s);
    assign up_add  = {1'b0, r_base} + {1'b0, r_up_size};
    assign mup_c   = r_up_vld && (up_diff == CW'(r_size)) && !up_add[32];

    // Valid bits and free entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.a_write) r_valid[r_aidx] <= 1'b1;
            if (i_cmd.a_clear) r_valid[r_aidx] <= 1'b0;
            if (i_cmd.sh_fin) begin
                r_count <= r_dir_down ? r_count - FCW'(1) : r_count + FCW'(1);
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_s      <= ADDR_BITS'(i_seg_start);
            r_size   <= i_seg_size;
            r_owner  <= i_owner_id;
            r_aidx   <= '0;
            r_fidx   <= '0;
            r_lo_vld <= 1'b0;
            r_up_vld <= 1'b0;
            r_status <= sfc_pkg::STS_OK;
            r_freed  <= '0;
        end
        if (i_cmd.a_inc) r_aidx <= r_aidx + AAW'(1);
        if (i_cmd.cap_found) begin
            r_size  <= rd_asize;
            r_owner <= rd_aowner;
        end
        if (i_cmd.cap_lo) begin
            r_lo_start <= rd_fstart;
            r_lo_size  <= rd_fsize;
            r_lo_vld   <= 1'b1;
            r_fidx     <= r_fidx + FCW'(1);
        end
        if (i_cmd.cap_up) begin
            r_up_start <= rd_fstart;
            r_up_size  <= rd_fsize;
            r_up_vld   <= 1'b1;
        end
        if (i_cmd.dec_lo) begin
            r_p    <= r_fidx;
            r_mlo  <= mlo_c;
            r_base <= mlo_c ? lo_add[31:0] : r_size;
        end
        if (i_cmd.dec_up) begin
            r_mup <= mup_c;
            r_sum <= up_add[31:0];
        end
        if (i_cmd.sh_down) r_dir_down <= 1'b1;
        if (i_cmd.sh_up) begin
            r_dir_down <= 1'b0;
            r_fidx     <= r_count;
        end
        if (i_cmd.sh_wr) begin
            r_fidx <= r_dir_down ? r_fidx + FCW'(1) : r_fidx - FCW'(1);
        end
        if (i_cmd.set_st) r_status <= i_cmd.st_val;
        if (i_cmd.a_clear) r_freed <= r_owner;
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_freed   <= r_freed;
            r_o_entries <= 7'(r_count);
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts             = '0;
        o_sts.func        = r_func;
        o_sts.null_addr   = (r_s == '0);
        o_sts.slot_valid  = r_valid[r_aidx];
        o_sts.a_last      = (r_aidx == AAW'(ALLOC_SLOTS - 1));
        o_sts.start_match = (rd_astart == r_s);
        o_sts.f_at_end    = (r_fidx >= r_count);
        o_sts.f_less      = (rd_fstart < r_s);
        o_sts.mlo         = r_mlo;
        o_sts.mup         = r_mup;
        o_sts.full        = (r_count >= FCW'(FREE_SLOTS));
        o_sts.sh_end      = r_dir_down ? (r_fidx + FCW'(1) >= r_count) : (r_fidx == r_p);
    end

    assign o_free_cnt     = r_count;
    assign o_status       = r_o_status;
    assign o_freed_owner  = r_o_freed;
    assign o_free_entries = r_o_entries;

endmodule

// File: rtl/segment_free_with_coalescing.sv
// Top level of the segment free list with coalescing.
// Depends on sfc_pkg, sfc_ctrl and sfc_dp (which holds the sfc_ram tables).
//
//  channel  | handshake                  | payload
//  request  | i_in_valid / o_in_ready    | i_func, i_seg_start, i_seg_size, i_owner_id
//  result   | o_out_valid / i_out_ready  | o_status, o_freed_owner, o_free_entries
//
// One request is worked at a time. A record scans the valid bits one slot a
// cycle; a free reads the allocated start table through S_FR_RD and S_FR_CHK
// for each slot, then walks the sorted free table through S_FS_RD and S_FS_CHK
// for each entry and shifts it through S_SH_RD and S_SH_WR for each moved entry,
// since each table RAM has one read and one write port. Reset clears the valid
// bits and the free count at once, no clearing pass.
// A stalled result holds in the output register;
// the next request is taken while it waits and finishes up to the result stage.
module segment_free_with_coalescing #(
    parameter int ALLOC_SLOTS = sfc_pkg::ALLOC_SLOTS_DEF,
    parameter int FREE_SLOTS  = sfc_pkg::FREE_SLOTS_DEF,
    parameter int ADDR_BITS   = sfc_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_seg_start,
    input  logic [31:0] i_seg_size,
    input  logic [15:0] i_owner_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_freed_owner,
    output logic [6:0]  o_free_entries
);

    localparam int FCW = $clog2(FREE_SLOTS + 1);

    sfc_pkg::t_cmd  cmd;
    sfc_pkg::t_sts  sts;
    logic [FCW-1:0] free_cnt;

    // Controller.
    sfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    sfc_dp #(
        .ALLOC_SLOTS(ALLOC_SLOTS),
        .FREE_SLOTS (FREE_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_seg_start   (i_seg_start),
        .i_seg_size    (i_seg_size),
        .i_owner_id    (i_owner_id),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_free_cnt    (free_cnt),
        .o_status      (o_status),
        .o_freed_owner (o_freed_owner),
        .o_free_entries(o_free_entries)
    );

    // The free table never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        free_cnt <= FCW'(FREE_SLOTS))
        else $error("free entry count exceeds table size");

    // The free entry count moves by at most one per request.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (free_cnt == $past(free_cnt)) || (free_cnt == $past(free_cnt) + FCW'(1))
        || (free_cnt == $past(free_cnt) - FCW'(1)))
        else $error("free entry count jumped");

    // A shift step never runs in the same cycle as a merge write.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_merge && (cmd.sh_wr || cmd.sh_fin)))
        else $error("conflicting free table writes");

endmodule
